[rtl/core/ecc_pkg.sv]
// ----------------------------------------------------------------------------
// ecc_pkg: shared types, codes and constants of the e-compass core
// Transaction structs, action and register codes, the CORDIC arctangent table
// and the CORDIC gain, which is worked out at elaboration.
// ----------------------------------------------------------------------------
package ecc_pkg;

  // Action codes of a sample transaction
  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_CANCEL = 2'd2;

  // Configuration register indexes
  localparam int CFG_IW = 1;
  localparam logic [CFG_IW-1:0] REG_DECL   = 1'd0;
  localparam logic [CFG_IW-1:0] REG_TARGET = 1'd1;

  localparam logic signed [15:0] DECL_RESET   = 16'sd0;
  localparam logic [15:0]        TARGET_RESET = 16'd40;

  localparam int CORDIC_ITERS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int ATAN_IW          = 5;
  // CORDIC datapath width, covers the gain of three chained passes
  localparam int CW = 40;

  localparam logic [17:0] FIELD_MAX = 18'h3FFFF;
  localparam logic [15:0] CDEG_TURN = 16'd36000;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } sample_t;

  typedef struct packed {
    logic [15:0] heading_cdeg;
    logic        heading_valid;
    logic        is_calibrated;
    logic        is_calibrating;
    logic [6:0]  cal_progress;
    logic [17:0] field_half_ut;
  } result_t;

  typedef struct packed {
    logic start;
    logic vec;
  } cordic_cmd_t;

  // Arctangent of 2^-i as a binary angle, 2^32 per turn
  function automatic logic [31:0] atan_entry(input logic [ATAN_IW-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // CORDIC gain in Q30: square root of the product of (1 + 2^-2i)
  function automatic logic [31:0] gain_q30(input int n);
    logic [63:0] p;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    p = 64'd1 << 30;
    for (int i = 0; i < n; i++) begin
      p = p + (p >> (2 * i));
    end
    v = p << 30;
    res = 64'd0;
    for (int k = 0; k < 32; k++) begin
      b = 64'd1 << (62 - 2 * k);
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
    end
    return res[31:0];
  endfunction

endpackage

[rtl/core/ecc_div.sv]
// ----------------------------------------------------------------------------
// ecc_div: bit-serial divider for calibration progress
// Restoring division, one quotient bit a cycle; the quotient is known to be
// below 128, so seven quotient bits cover it.
// ----------------------------------------------------------------------------
module ecc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [22:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [6:0]  quo
);

  logic        busy;
  logic [2:0]  cnt;
  logic [22:0] r;
  logic [21:0] ds;
  logic        ge;

  assign ge = (r >= {1'b0, ds});

  // Sequence the seven steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd6) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Subtract the shifted divisor where it fits, shift in the quotient bit
  always_ff @(posedge clk) begin
    if (start) begin
      r   <= num;
      ds  <= {den, 6'b0};
      quo <= 7'd0;
    end else if (busy) begin
      if (ge) begin
        r <= r - {1'b0, ds};
      end
      quo <= {quo[5:0], ge};
      ds  <= ds >> 1;
    end
  end

endmodule

[rtl/core/ecc_sqrt.sv]
// ----------------------------------------------------------------------------
// ecc_sqrt: digit-serial integer square root
// Takes a 64-bit radicand two bits a cycle from a shift register and builds
// the 32-bit floor root one bit a cycle.
// ----------------------------------------------------------------------------
module ecc_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] rs;
  logic [35:0] rem;
  logic [35:0] rem_n;
  logic [35:0] trial;
  logic        ge;

  assign rem_n = {rem[33:0], rs[63:62]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = (rem_n >= trial);

  // Sequence the 32 digit steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Bring in two radicand bits, try the next root bit
  always_ff @(posedge clk) begin
    if (start) begin
      rs   <= rad;
      rem  <= 36'd0;
      root <= 32'd0;
    end else if (busy) begin
      rs   <= rs << 2;
      rem  <= ge ? (rem_n - trial) : rem_n;
      root <= {root[30:0], ge};
    end
  end

endmodule

[rtl/core/ecc_cordic.sv]
// ----------------------------------------------------------------------------
// ecc_cordic: iterative CORDIC for vectoring and rotation
// One micro-rotation a cycle. Vectoring gives atan2(y, x) as a binary angle;
// rotation turns (x, y) counterclockwise by th and carries the gain.
// ----------------------------------------------------------------------------
module ecc_cordic #(
  parameter int ITERS = ecc_pkg::CORDIC_ITERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ecc_pkg::cordic_cmd_t           cmd,
  input  logic signed [ecc_pkg::CW-1:0]  x0,
  input  logic signed [ecc_pkg::CW-1:0]  y0,
  input  logic [31:0]                    th,
  output logic                           done,
  output logic signed [ecc_pkg::CW-1:0]  x,
  output logic signed [ecc_pkg::CW-1:0]  y,
  output logic [31:0]                    angle
);

  localparam int IW = (ITERS > 1) ? $clog2(ITERS) : 1;
  localparam logic [IW-1:0] LAST = IW'(ITERS - 1);

  logic                          busy;
  logic [IW-1:0]                 i;
  logic                          vec;
  logic                          zero;
  logic signed [33:0]            z;
  logic signed [ecc_pkg::CW-1:0] dxs;
  logic signed [ecc_pkg::CW-1:0] dys;
  logic signed [33:0]            at;
  logic                          ccw;
  logic                          fold;
  logic [31:0]                   thf;

  assign dxs   = y >>> i;
  assign dys   = x >>> i;
  assign at    = $signed({2'b00, ecc_pkg::atan_entry(ecc_pkg::ATAN_IW'(i))});
  assign ccw   = vec ? y[ecc_pkg::CW-1] : ~z[33];
  assign fold  = (th[31:30] == 2'd1) || (th[31:30] == 2'd2);
  assign thf   = fold ? (th ^ 32'h8000_0000) : th;
  assign angle = zero ? 32'd0 : z[31:0];

  // Count the micro-rotations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        i    <= '0;
      end else if (busy) begin
        i <= i + 1'b1;
        if (i == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Fold into the right half plane, then rotate toward the target
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      vec <= cmd.vec;
      if (cmd.vec) begin
        zero <= (x0 == '0) && (y0 == '0);
        if (x0 < 0) begin
          x <= -x0;
          y <= -y0;
          z <= 34'sh0_8000_0000;
        end else begin
          x <= x0;
          y <= y0;
          z <= '0;
        end
      end else begin
        zero <= 1'b0;
        x    <= fold ? -x0 : x0;
        y    <= fold ? -y0 : y0;
        z    <= $signed({{2{thf[31]}}, thf});
      end
    end else if (busy) begin
      if (ccw) begin
        x <= x - dxs;
        y <= y + dys;
        z <= z - at;
      end else begin
        x <= x + dxs;
        y <= y - dys;
        z <= z + at;
      end
    end
  end

endmodule

[rtl/core/ecompass_calibrate_and_heading_top.sv]
// ----------------------------------------------------------------------------
// ecompass_calibrate_and_heading_top: hard-iron calibration and tilt-
// compensated heading
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+----------------------
//   sample   | in        | sample_valid/sample_stall | ecc_pkg::sample_t
//   result   | out       | result_valid/result_stall | ecc_pkg::result_t
//   cfg      | in        | cfg_write                 | cfg_index, cfg_data
//
// A calibration event or calibrating sample runs the calibration states, plus
// the progress divider while the smallest span is below the target. A heading
// sample adds two square roots and five CORDIC passes on the one shared unit.
// One transaction is in work at a time; the next is taken once its result is
// in the output register. Reset is synchronous and clears state and flags.
// ----------------------------------------------------------------------------
module ecompass_calibrate_and_heading_top #(
  parameter int CORDIC_ITERS = ecc_pkg::CORDIC_ITERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  ecc_pkg::sample_t           sample,
  output logic                       result_valid,
  input  logic                       result_stall,
  output ecc_pkg::result_t           result,
  input  logic                       cfg_write,
  input  logic [ecc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [15:0]                cfg_data
);

  localparam int CW = ecc_pkg::CW;
  localparam logic signed [31:0] KQ = $signed(ecc_pkg::gain_q30(CORDIC_ITERS));

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CAL   = 5'd1;
  localparam logic [4:0] S_PROG  = 5'd2;
  localparam logic [4:0] S_DIVW  = 5'd3;
  localparam logic [4:0] S_FIN   = 5'd4;
  localparam logic [4:0] S_MDX   = 5'd5;
  localparam logic [4:0] S_MDY   = 5'd6;
  localparam logic [4:0] S_MDZ   = 5'd7;
  localparam logic [4:0] S_MA1   = 5'd8;
  localparam logic [4:0] S_MA2   = 5'd9;
  localparam logic [4:0] S_MY    = 5'd10;
  localparam logic [4:0] S_SQF   = 5'd11;
  localparam logic [4:0] S_SQFW  = 5'd12;
  localparam logic [4:0] S_SQR   = 5'd13;
  localparam logic [4:0] S_SQRW  = 5'd14;
  localparam logic [4:0] S_ROLL  = 5'd15;
  localparam logic [4:0] S_ROLLW = 5'd16;
  localparam logic [4:0] S_PIT   = 5'd17;
  localparam logic [4:0] S_PITW  = 5'd18;
  localparam logic [4:0] S_ROT1  = 5'd19;
  localparam logic [4:0] S_ROT1W = 5'd20;
  localparam logic [4:0] S_ROT2  = 5'd21;
  localparam logic [4:0] S_ROT2W = 5'd22;
  localparam logic [4:0] S_MX    = 5'd23;
  localparam logic [4:0] S_XS    = 5'd24;
  localparam logic [4:0] S_VEC   = 5'd25;
  localparam logic [4:0] S_VECW  = 5'd26;
  localparam logic [4:0] S_CD    = 5'd27;
  localparam logic [4:0] S_CD2   = 5'd28;
  localparam logic [4:0] S_OUT   = 5'd29;

  logic [4:0]         state;
  ecc_pkg::sample_t   it;
  logic signed [15:0] decl;
  logic [15:0]        tgt;
  logic signed [15:0] amin [3];
  logic signed [15:0] amax [3];
  logic signed [16:0] off [3];
  logic               calibrating;
  logic               calibrated;
  logic [17:0]        last_field;
  logic               hd;
  logic               samp_cal;
  logic [6:0]         prog;
  logic signed [67:0] mp;
  logic [35:0]        sum;
  logic [31:0]        ryz;
  logic [31:0]        rr;
  logic [31:0]        roll;
  logic [31:0]        pitch;
  logic [31:0]        ang;
  logic signed [CW-1:0] xr;
  logic signed [CW-1:0] yr;
  logic signed [CW-1:0] zr;
  logic [15:0]        hcd;

  logic signed [15:0] mag [3];
  logic signed [15:0] acc [3];
  logic signed [17:0] dx;
  logic signed [17:0] dy;
  logic signed [17:0] dz;
  logic signed [16:0] span [3];
  logic               span_neg;
  logic [15:0]        minspan;
  logic [15:0]        tgt_eff;
  logic signed [35:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [67:0] mp_sh;
  logic [47:0]        cd_full;
  logic [15:0]        cd0;
  logic signed [17:0] cds;
  logic signed [17:0] cdw;

  logic               div_start;
  logic               div_done;
  logic [6:0]         div_q;
  logic               sq_start;
  logic [63:0]        sq_rad;
  logic               sq_done;
  logic [31:0]        sq_root;
  ecc_pkg::cordic_cmd_t cor_cmd;
  logic signed [CW-1:0] cor_x0;
  logic signed [CW-1:0] cor_y0;
  logic [31:0]        cor_th;
  logic               cor_done;
  logic signed [CW-1:0] cor_x;
  logic signed [CW-1:0] cor_y;
  logic [31:0]        cor_ang;

  assign mag[0] = it.mag_x;
  assign mag[1] = it.mag_y;
  assign mag[2] = it.mag_z;
  assign acc[0] = it.accel_x;
  assign acc[1] = it.accel_y;
  assign acc[2] = it.accel_z;

  assign sample_stall = (state != S_IDLE);

  // Offset-corrected axes in half microtesla
  assign dx = $signed({mag[0][15], mag[0], 1'b0}) - $signed({off[0][16], off[0]});
  assign dy = $signed({mag[1][15], mag[1], 1'b0}) - $signed({off[1][16], off[1]});
  assign dz = $signed({mag[2][15], mag[2], 1'b0}) - $signed({off[2][16], off[2]});

  // Smallest axis span for progress
  always_comb begin
    span_neg = 1'b0;
    minspan  = 16'hFFFF;
    for (int k = 0; k < 3; k++) begin
      span[k] = $signed({amax[k][15], amax[k]}) - $signed({amin[k][15], amin[k]});
      if (span[k] < 0) begin
        span_neg = 1'b1;
      end else if (span[k][15:0] < minspan) begin
        minspan = span[k][15:0];
      end
    end
  end
  assign tgt_eff = (tgt == 16'd0) ? 16'd1 : tgt;

  // Shared multiplier operands
  always_comb begin
    case (state)
      S_MDX: begin
        mul_a = 36'(dx);
        mul_b = 32'(dx);
      end
      S_MDY: begin
        mul_a = 36'(dy);
        mul_b = 32'(dy);
      end
      S_MDZ: begin
        mul_a = 36'(dz);
        mul_b = 32'(dz);
      end
      S_MA1: begin
        mul_a = 36'(acc[1]);
        mul_b = 32'(acc[1]);
      end
      S_MA2: begin
        mul_a = 36'(acc[2]);
        mul_b = 32'(acc[2]);
      end
      S_MY: begin
        mul_a = $signed({{6{dy[17]}}, dy, 12'b0});
        mul_b = KQ;
      end
      S_MX: begin
        mul_a = $signed(xr[35:0]);
        mul_b = KQ;
      end
      S_CD: begin
        mul_a = $signed({4'b0, ang});
        mul_b = 32'sd36000;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mp_sh = mp >>> 30;

  // Round the binary heading to centidegrees, add declination, wrap
  assign cd_full = mp[47:0] + 48'h0000_8000_0000;
  assign cd0     = (cd_full[47:32] >= ecc_pkg::CDEG_TURN) ? 16'd0 : cd_full[47:32];
  assign cds     = $signed({2'b00, cd0}) + 18'(decl);
  always_comb begin
    if (cds >= $signed({2'b00, ecc_pkg::CDEG_TURN})) begin
      cdw = cds - $signed({2'b00, ecc_pkg::CDEG_TURN});
    end else if (cds < 0) begin
      cdw = cds + $signed({2'b00, ecc_pkg::CDEG_TURN});
    end else begin
      cdw = cds;
    end
  end

  // Square root radicand: field power, or accel YZ power scaled by 2^32
  assign sq_start = (state == S_SQF) || (state == S_SQR);
  assign sq_rad   = (state == S_SQF) ? {28'b0, sum} : {ryz, 32'b0};

  assign div_start = (state == S_PROG) && calibrating && !span_neg && (minspan < tgt_eff);

  // CORDIC command and operands
  always_comb begin
    cor_cmd.start = 1'b0;
    cor_cmd.vec   = 1'b0;
    cor_x0        = '0;
    cor_y0        = '0;
    cor_th        = 32'd0;
    case (state)
      S_ROLL: begin
        cor_cmd.start = 1'b1;
        cor_cmd.vec   = 1'b1;
        cor_x0 = $signed({{(CW-32){acc[2][15]}}, acc[2], 16'b0});
        cor_y0 = $signed({{(CW-32){acc[1][15]}}, acc[1], 16'b0});
      end
      S_PIT: begin
        cor_cmd.start = 1'b1;
        cor_cmd.vec   = 1'b1;
        cor_x0 = $signed({{(CW-32){1'b0}}, rr});
        cor_y0 = -$signed({{(CW-32){acc[0][15]}}, acc[0], 16'b0});
      end
      S_ROT1: begin
        cor_cmd.start = 1'b1;
        cor_x0 = $signed({{(CW-30){dx[17]}}, dx, 12'b0});
        cor_y0 = $signed({{(CW-30){dz[17]}}, dz, 12'b0});
        cor_th = 32'd0 - pitch;
      end
      S_ROT2: begin
        cor_cmd.start = 1'b1;
        cor_x0 = yr;
        cor_y0 = zr;
        cor_th = roll;
      end
      S_VEC: begin
        cor_cmd.start = 1'b1;
        cor_cmd.vec   = 1'b1;
        cor_x0 = xr;
        cor_y0 = yr;
      end
      default: begin
        cor_cmd.start = 1'b0;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      decl <= ecc_pkg::DECL_RESET;
      tgt  <= ecc_pkg::TARGET_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ecc_pkg::REG_DECL:   decl <= $signed(cfg_data);
        ecc_pkg::REG_TARGET: tgt  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer and calibration state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      calibrating  <= 1'b0;
      calibrated   <= 1'b0;
      last_field   <= 18'd0;
      result_valid <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        amin[k] <= 16'sh7FFF;
        amax[k] <= -16'sh8000;
        off[k]  <= '0;
      end
    end else begin
      // Drop the result once taken, unless a new one loads at the same edge
      if (result_valid && !result_stall && (state != S_OUT)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            state <= S_CAL;
          end
        end
        S_CAL: begin
          case (it.action)
            ecc_pkg::ACT_START: begin
              for (int k = 0; k < 3; k++) begin
                amin[k] <= 16'sh7FFF;
                amax[k] <= -16'sh8000;
              end
              calibrating <= 1'b1;
            end
            ecc_pkg::ACT_CANCEL: begin
              calibrating <= 1'b0;
            end
            ecc_pkg::ACT_SAMPLE: begin
              if (calibrating) begin
                for (int k = 0; k < 3; k++) begin
                  if (mag[k] < amin[k]) amin[k] <= mag[k];
                  if (mag[k] > amax[k]) amax[k] <= mag[k];
                end
              end
            end
            default: begin
            end
          endcase
          state <= S_PROG;
        end
        S_PROG: begin
          state <= div_start ? S_DIVW : S_FIN;
        end
        S_DIVW: begin
          if (div_done) state <= S_FIN;
        end
        S_FIN: begin
          if (samp_cal && (prog == 7'd100)) begin
            for (int k = 0; k < 3; k++) begin
              off[k] <= $signed({amax[k][15], amax[k]}) + $signed({amin[k][15], amin[k]});
            end
            calibrating <= 1'b0;
            calibrated  <= 1'b1;
          end
          state <= hd ? S_MDX : S_OUT;
        end
        S_MDX:   state <= S_MDY;
        S_MDY:   state <= S_MDZ;
        S_MDZ:   state <= S_MA1;
        S_MA1:   state <= S_MA2;
        S_MA2:   state <= S_MY;
        S_MY:    state <= S_SQF;
        S_SQF:   state <= S_SQFW;
        S_SQFW: begin
          if (sq_done) begin
            last_field <= (sq_root > {14'd0, ecc_pkg::FIELD_MAX}) ?
                          ecc_pkg::FIELD_MAX : sq_root[17:0];
            state <= S_SQR;
          end
        end
        S_SQR:   state <= S_SQRW;
        S_SQRW:  if (sq_done) state <= S_ROLL;
        S_ROLL:  state <= S_ROLLW;
        S_ROLLW: if (cor_done) state <= S_PIT;
        S_PIT:   state <= S_PITW;
        S_PITW:  if (cor_done) state <= S_ROT1;
        S_ROT1:  state <= S_ROT1W;
        S_ROT1W: if (cor_done) state <= S_ROT2;
        S_ROT2:  state <= S_ROT2W;
        S_ROT2W: if (cor_done) state <= S_MX;
        S_MX:    state <= S_XS;
        S_XS:    state <= S_VEC;
        S_VEC:   state <= S_VECW;
        S_VECW:  if (cor_done) state <= S_CD;
        S_CD:    state <= S_CD2;
        S_CD2:   state <= S_OUT;
        S_OUT: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mp <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        if (sample_valid) it <= sample;
      end
      S_CAL: begin
        hd       <= (it.action == ecc_pkg::ACT_SAMPLE) && !calibrating;
        samp_cal <= (it.action == ecc_pkg::ACT_SAMPLE) && calibrating;
      end
      S_PROG: begin
        if (!calibrating || span_neg) begin
          prog <= 7'd0;
        end else if (minspan >= tgt_eff) begin
          prog <= 7'd100;
        end
      end
      S_DIVW: begin
        if (div_done) prog <= div_q;
      end
      S_FIN: begin
        if (samp_cal && (prog == 7'd100)) prog <= 7'd0;
      end
      S_MDY:   sum <= mp[35:0];
      S_MDZ:   sum <= sum + mp[35:0];
      S_MA1:   sum <= sum + mp[35:0];
      S_MA2:   ryz <= mp[31:0];
      S_MY:    ryz <= ryz + mp[31:0];
      S_SQF:   yr  <= mp_sh[CW-1:0];
      S_SQRW:  if (sq_done) rr <= sq_root;
      S_ROLLW: if (cor_done) roll <= cor_ang;
      S_PITW:  if (cor_done) pitch <= cor_ang;
      S_ROT1W: begin
        if (cor_done) begin
          xr <= cor_x;
          zr <= cor_y;
        end
      end
      S_ROT2W: if (cor_done) yr <= cor_x;
      S_XS:    xr <= mp_sh[CW-1:0];
      S_VECW:  if (cor_done) ang <= cor_ang;
      S_CD2:   hcd <= cdw[15:0];
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!result_valid || !result_stall)) begin
      result.heading_cdeg   <= hd ? hcd : 16'd0;
      result.heading_valid  <= hd;
      result.is_calibrated  <= calibrated;
      result.is_calibrating <= calibrating;
      result.cal_progress   <= prog;
      result.field_half_ut  <= last_field;
    end
  end

  ecc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (23'(minspan) * 23'd100),
    .den   (tgt_eff),
    .done  (div_done),
    .quo   (div_q)
  );

  ecc_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .rad   (sq_rad),
    .done  (sq_done),
    .root  (sq_root)
  );

  ecc_cordic #(
    .ITERS (CORDIC_ITERS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cor_cmd),
    .x0    (cor_x0),
    .y0    (cor_y0),
    .th    (cor_th),
    .done  (cor_done),
    .x     (cor_x),
    .y     (cor_y),
    .angle (cor_ang)
  );

endmodule
